// ===== hdl/r14_pkg.sv =====
// ----------------------------------------------------------------------------
// r14_pkg - shared types and constants for the raw14 unpack / scale block
// Widths of the packed block, samples and pixels, register codes and the
// control structs passed between the top level, the lanes and the merge stage.
// ----------------------------------------------------------------------------
package r14_pkg;

	localparam int LANES      = 8;
	localparam int SAMPLE_W   = 14;
	localparam int GAIN_W     = 32;
	localparam int PIX_W      = 16;
	localparam int PROD_W     = SAMPLE_W + GAIN_W;
	localparam int BLK_LO_W   = 64;
	localparam int BLK_HI_W   = 48;
	localparam int BLK_W      = BLK_LO_W + BLK_HI_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = GAIN_W;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32'h0001_0000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_LEVEL = 1'b0,
		REG_GAIN       = 1'b1
	} cfg_reg_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [PIX_W-1:0]    pixel_t;
	typedef sample_t             sample_arr_t [LANES];
	typedef pixel_t              pixel_arr_t  [LANES];

	// per-stage load enables, shared by every lane
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} pipe_ctrl_t;

endpackage

// ===== hdl/r14_ifs.sv =====
// ----------------------------------------------------------------------------
// r14 channel interfaces
// Valid/ready channels for packed input blocks and scaled pixel results.
// ----------------------------------------------------------------------------
interface r14_blk_if import r14_pkg::*;;
	logic                valid;
	logic                ready;
	logic [BLK_LO_W-1:0] block_low;
	logic [BLK_HI_W-1:0] block_high;

	modport source (output valid, output block_low, output block_high, input ready);
	modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

interface r14_pix_if import r14_pkg::*;;
	logic   valid;
	logic   ready;
	pixel_t pixel_0;
	pixel_t pixel_1;
	pixel_t pixel_2;
	pixel_t pixel_3;
	pixel_t pixel_4;
	pixel_t pixel_5;
	pixel_t pixel_6;
	pixel_t pixel_7;

	modport source (output valid, output pixel_0, output pixel_1, output pixel_2,
		output pixel_3, output pixel_4, output pixel_5, output pixel_6,
		output pixel_7, input ready);
	modport sink   (input valid, input pixel_0, input pixel_1, input pixel_2,
		input pixel_3, input pixel_4, input pixel_5, input pixel_6,
		input pixel_7, output ready);
endinterface

// ===== hdl/raw14_unpack_black_scale.sv =====
// Stages: diff_s1, prod_s2, merge output register. Throughput: one block per
// cycle while pixels.ready is high; each of the eight lanes has one 14x32
// multiplier and the three register stages advance independently on ready.
// Reset: arst_n clears all valid flags; dark_level returns to 0 and gain
// to 1.0 (Q16.16). No clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// raw14_unpack_black_scale - packed 14-bit raw unpack, black level and gain
// Splits a 112-bit block into eight samples and scales them in parallel lanes.
// ----------------------------------------------------------------------------
module raw14_unpack_black_scale import r14_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	r14_blk_if.sink               blocks,
	r14_pix_if.source             pixels
);

	sample_t           dark_level_q;
	logic [GAIN_W-1:0] gain_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              rdy1;
	logic              rdy2;
	logic              rdy3;
	pipe_ctrl_t        ctrl;
	logic [BLK_W-1:0]  blk;
	sample_arr_t       smp;
	pixel_arr_t        pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_level_q <= '0;
			gain_q       <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DARK_LEVEL: dark_level_q <= cfg_data[SAMPLE_W-1:0];
				REG_GAIN:       gain_q       <= cfg_data[GAIN_W-1:0];
				default:        ;
			endcase
		end
	end

	// high part sits above the low part in each rebuilt sample
	assign blk    = {blocks.block_high, blocks.block_low};
	assign smp[0] = blk[15:2];
	assign smp[1] = {blk[1:0],   blk[31:20]};
	assign smp[2] = {blk[19:16], blk[47:38]};
	assign smp[3] = {blk[37:32], blk[63:56]};
	assign smp[4] = {blk[55:48], blk[79:74]};
	assign smp[5] = {blk[73:64], blk[95:92]};
	assign smp[6] = {blk[91:80], blk[111:110]};
	assign smp[7] = blk[109:96];

	assign rdy2         = !valid_s2 || rdy3;
	assign rdy1         = !valid_s1 || rdy2;
	assign ctrl.en_s1   = rdy1;
	assign ctrl.en_s2   = rdy2;
	assign blocks.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= blocks.valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		r14_lane u_lane (
			.clk        (clk),
			.ctrl       (ctrl),
			.sample     (smp[i]),
			.dark_level (dark_level_q),
			.gain       (gain_q),
			.pixel      (pix[i])
		);
	end

	r14_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.pix      (pix),
		.load     (rdy3),
		.pixels   (pixels)
	);

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		blocks.valid && blocks.ready |=> valid_s1)
		else $error("accepted block did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rdy2 |=> valid_s1)
		else $error("stage 1 dropped a transaction while stalled");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rdy3 |=> pixels.valid)
		else $error("stage 2 transaction lost before output register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && !pixels.ready && valid_s2 |-> !rdy2)
		else $error("stage 2 advanced into a full output register");
`endif

endmodule

// ===== hdl/r14_lane.sv =====
// ----------------------------------------------------------------------------
// r14_lane - one sample lane
// Black level subtract with clamp at zero, Q16.16 gain multiply, then
// truncation and saturation of the product to a 16-bit pixel.
// ----------------------------------------------------------------------------
module r14_lane import r14_pkg::*; (
	input  logic              clk,
	input  pipe_ctrl_t        ctrl,
	input  sample_t           sample,
	input  sample_t           dark_level,
	input  logic [GAIN_W-1:0] gain,
	output pixel_t            pixel
);

	sample_t           diff_s1;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			diff_s1 <= (sample > dark_level) ? sample - dark_level : '0;
		end
		if (ctrl.en_s2) begin
			prod_s2 <= PROD_W'(diff_s1) * PROD_W'(gain);
		end
	end

	// drop 16 fraction bits; anything above bit 31 means overflow
	always_comb begin
		if (|prod_s2[PROD_W-1:PIX_W+16]) begin
			pixel = '1;
		end else begin
			pixel = prod_s2[PIX_W+15:16];
		end
	end

endmodule

// ===== hdl/r14_merge.sv =====
// ----------------------------------------------------------------------------
// r14_merge - output stage
// Collects the eight lane pixels into one registered result transaction and
// tells the pipeline when that register can take a new one.
// ----------------------------------------------------------------------------
module r14_merge import r14_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  pixel_arr_t pix,
	output logic       load,
	r14_pix_if.source  pixels
);

	logic       valid_q;
	pixel_arr_t pix_q;

	assign load = !valid_q || pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= pix;
		end
	end

	assign pixels.valid   = valid_q;
	assign pixels.pixel_0 = pix_q[0];
	assign pixels.pixel_1 = pix_q[1];
	assign pixels.pixel_2 = pix_q[2];
	assign pixels.pixel_3 = pix_q[3];
	assign pixels.pixel_4 = pix_q[4];
	assign pixels.pixel_5 = pix_q[5];
	assign pixels.pixel_6 = pix_q[6];
	assign pixels.pixel_7 = pix_q[7];

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - testbench for raw14_unpack_black_scale
// Drives packed 112-bit blocks through the valid/ready input channel, predicts
// the eight scaled pixels of each block, checks them against the pixel
// channel in order, and walks several black level / gain settings.
// ----------------------------------------------------------------------------
module tb;
	import r14_pkg::*;

	typedef logic [LANES-1:0][SAMPLE_W-1:0] samp_vec_t;
	typedef logic [LANES-1:0][PIX_W-1:0]    pix_vec_t;

	typedef struct {
		logic [BLK_W-1:0]      blk;
		logic [CFG_DATA_W-1:0] black_data;
		logic [CFG_DATA_W-1:0] gain_data;
		bit                    fixed_ok;
		pix_vec_t              fixed;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	r14_blk_if blk_ch ();
	r14_pix_if pix_ch ();

	raw14_unpack_black_scale u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blocks    (blk_ch),
		.pixels    (pix_ch)
	);

	// local copy of the register file
	sample_t           black_lvl;
	logic [GAIN_W-1:0] gain_q;

	pix_vec_t pend_pix [$];
	dir_row_t dir_rows [$];
	int       err_cnt;
	bit       idle_on;
	bit       hold_req;
	int       hold_left;
	bit       row_fixed_ok;
	pix_vec_t row_fixed;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic pixel_t scale_px(input sample_t s);
		logic [PROD_W-1:0] prod;
		logic [PROD_W-17:0] shifted;
		if (s <= black_lvl)
			return '0;
		prod = PROD_W'(s - black_lvl) * PROD_W'(gain_q);
		shifted = prod[PROD_W-1:16];
		return (shifted > (PROD_W-16)'(16'hFFFF)) ? 16'hFFFF : shifted[15:0];
	endfunction

	function automatic pix_vec_t predict_pixels(input logic [BLK_W-1:0] b);
		samp_vec_t s;
		pix_vec_t  p;
		s[0] = b[15:2];
		s[1] = {b[1:0],   b[31:20]};
		s[2] = {b[19:16], b[47:38]};
		s[3] = {b[37:32], b[63:56]};
		s[4] = {b[55:48], b[79:74]};
		s[5] = {b[73:64], b[95:92]};
		s[6] = {b[91:80], b[111:110]};
		s[7] = b[109:96];
		for (int k = 0; k < LANES; k++)
			p[k] = scale_px(s[k]);
		return p;
	endfunction

	// inverse of the unpack: place eight samples into a block
	function automatic logic [BLK_W-1:0] pack_samples(input samp_vec_t s);
		logic [BLK_W-1:0] b;
		b = '0;
		b[15:2]    = s[0];
		b[31:20]   = s[1][11:0];  b[1:0]   = s[1][13:12];
		b[47:38]   = s[2][9:0];   b[19:16] = s[2][13:10];
		b[63:56]   = s[3][7:0];   b[37:32] = s[3][13:8];
		b[79:74]   = s[4][5:0];   b[55:48] = s[4][13:6];
		b[95:92]   = s[5][3:0];   b[73:64] = s[5][13:4];
		b[111:110] = s[6][1:0];   b[91:80] = s[6][13:2];
		b[109:96]  = s[7];
		return b;
	endfunction

	task automatic add_row(input logic [BLK_W-1:0] blk, input logic [31:0] black_data,
			input logic [31:0] gain_data, input bit fixed_ok, input pix_vec_t fixed);
		dir_row_t r;
		r.blk = blk;
		r.black_data = black_data;
		r.gain_data = gain_data;
		r.fixed_ok = fixed_ok;
		r.fixed = fixed;
		dir_rows.push_back(r);
	endtask

	// offer one block; returns at the accepting edge
	task automatic push_block(input logic [BLK_W-1:0] blk, input bit fixed_ok,
			input pix_vec_t fixed);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 30) begin
			blk_ch.valid <= 1'b0;
			@(negedge clk);
		end
		row_fixed_ok = fixed_ok;
		row_fixed = fixed;
		blk_ch.valid <= 1'b1;
		blk_ch.block_low <= blk[BLK_LO_W-1:0];
		blk_ch.block_high <= blk[BLK_W-1:BLK_LO_W];
		do @(posedge clk); while (!blk_ch.ready);
	endtask

	// drain the pipe, then write both registers
	task automatic set_config(input logic [31:0] black_data, input logic [31:0] gain_data);
		@(negedge clk);
		blk_ch.valid <= 1'b0;
		while (pend_pix.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DARK_LEVEL;
		cfg_data <= black_data;
		black_lvl = black_data[SAMPLE_W-1:0];
		@(negedge clk);
		cfg_index <= REG_GAIN;
		cfg_data <= gain_data;
		gain_q = gain_data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			pix_ch.ready <= 1'b0;
			hold_left--;
		end else if (idle_on) begin
			pix_ch.ready <= ($urandom_range(99) >= 30);
		end else begin
			pix_ch.ready <= 1'b1;
		end
	end

	// expectations are queued on input transactions, checked on output ones
	always @(posedge clk) begin : mon
		pix_vec_t got;
		pix_vec_t want;
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready) begin
				got = {pix_ch.pixel_7, pix_ch.pixel_6, pix_ch.pixel_5, pix_ch.pixel_4,
					pix_ch.pixel_3, pix_ch.pixel_2, pix_ch.pixel_1, pix_ch.pixel_0};
				if (pend_pix.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h",
						$time, got);
					err_cnt++;
				end else begin
					want = pend_pix.pop_front();
					for (int k = 0; k < LANES; k++)
						if (got[k] !== want[k]) begin
							$display("%0t: pixel_%0d expected %h actual %h",
								$time, k, want[k], got[k]);
							err_cnt++;
						end
				end
			end
			if (blk_ch.valid && blk_ch.ready)
				pend_pix.push_back(row_fixed_ok ? row_fixed :
					predict_pixels({blk_ch.block_high, blk_ch.block_low}));
		end
	end

	initial begin : main
		samp_vec_t        samp;
		logic [BLK_W-1:0] blk;
		logic [31:0]      bl_data;
		logic [31:0]      gn_data;
		logic [63:0]      diff;
		int               v;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DARK_LEVEL;
		cfg_data = '0;
		blk_ch.valid = 1'b0;
		blk_ch.block_low = '0;
		blk_ch.block_high = '0;
		pix_ch.ready = 1'b0;
		black_lvl = '0;
		gain_q = GAIN_RESET;
		err_cnt = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		hold_left = 0;
		row_fixed_ok = 1'b0;
		row_fixed = '0;

		// directed rows; the first group runs on the reset register values
		add_row('0, 32'd0, 32'h0001_0000, 1'b1, '0);
		add_row('1, 32'd0, 32'h0001_0000, 1'b1, {LANES{16'h3FFF}});
		for (int k = 0; k < LANES; k++) begin
			samp = '0;
			samp[k] = 14'h3FFF;
			add_row(pack_samples(samp), 32'd0, 32'h0001_0000, 1'b0, '0);
		end
		for (int k = 0; k < LANES; k++)
			samp[k] = SAMPLE_W'(k + 1);
		add_row(pack_samples(samp), 32'd0, 32'h0001_0000, 1'b0, '0);
		add_row({56'hAAAA_AAAA_AAAA_AA, 56'h5555_5555_5555_55}, 32'd0, 32'h0001_0000,
			1'b0, '0);
		// at black level -> clamp to zero
		add_row('1, 32'd16383, 32'hFFFF_0000, 1'b1, '0);
		add_row('0, 32'd16383, 32'hFFFF_0000, 1'b1, '0);
		// around black with junk above bit 13 of the write data
		samp = {14'd1, 14'd200, 14'h3FFF, 14'd0, 14'd102, 14'd101, 14'd100, 14'd99};
		add_row(pack_samples(samp), 32'hFFFF_C064, 32'hFFFF_0000, 1'b0, '0);
		// zero gain
		add_row('1, 32'd0, 32'd0, 1'b1, '0);
		// saturation
		add_row('1, 32'd0, 32'hFFFF_0000, 1'b1, {LANES{16'hFFFF}});
		add_row(pack_samples({LANES{14'd1}}), 32'd0, 32'hFFFF_0000, 1'b0, '0);
		// realistic setting: white 16383, black 1000
		add_row({$urandom, $urandom, $urandom, $urandom}, 32'd1000, 32'd279201, 1'b0, '0);
		add_row({$urandom, $urandom, $urandom, $urandom}, 32'd1000, 32'd279201, 1'b0, '0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].black_data[SAMPLE_W-1:0] != black_lvl ||
					dir_rows[i].gain_data != gain_q)
				set_config(dir_rows[i].black_data, dir_rows[i].gain_data);
			push_block(dir_rows[i].blk, dir_rows[i].fixed_ok, dir_rows[i].fixed);
		end

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin bl_data = 32'd0; gn_data = 32'h0001_0000; end
				1: begin
					bl_data = $urandom_range(0, 4000);
					diff = $urandom_range(1000, 16383 - bl_data);
					gn_data = 32'((64'd65535 << 16) / diff);
				end
				2: begin bl_data = 32'd16383; gn_data = $urandom; end
				3: begin bl_data = 32'd0; gn_data = 32'hFFFF_0000; end
				4: begin bl_data = $urandom_range(0, 16383); gn_data = 32'd0; end
				5: begin bl_data = $urandom; gn_data = $urandom; end
				6: begin bl_data = $urandom_range(0, 200); gn_data = $urandom_range(0, 32'h2_0000); end
				default: begin
					bl_data = $urandom;
					gn_data = 32'hFFFF_0000 - $urandom_range(0, 65535);
				end
			endcase
			set_config(bl_data, gn_data);
			// one phase without any idling on either side
			idle_on = (ph != 1);
			for (int n = 0; n < 231; n++) begin
				if ($urandom_range(99) < 60) begin
					for (int k = 0; k < LANES; k++)
						case ($urandom_range(3))
							0: samp[k] = '0;
							1: samp[k] = '1;
							2: begin
								v = int'(black_lvl) + int'($urandom_range(0, 6)) - 3;
								if (v < 0) v = 0;
								if (v > 16383) v = 16383;
								samp[k] = SAMPLE_W'(v);
							end
							default: samp[k] = SAMPLE_W'($urandom);
						endcase
					blk = pack_samples(samp);
				end else begin
					blk = {$urandom, $urandom, $urandom, $urandom};
				end
				push_block(blk, 1'b0, '0);
				if (ph == 5 && n == 10)
					hold_req = 1'b1;
			end
		end

		@(negedge clk);
		blk_ch.valid <= 1'b0;
		while (pend_pix.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/r14_pkg.sv
hdl/r14_ifs.sv
hdl/r14_lane.sv
hdl/r14_merge.sv
hdl/raw14_unpack_black_scale.sv
bench/tb.sv
